### src/dmpd_pkg.sv
// ----------------------------------------------------------------------------
// dmpd_pkg
// Shared types and constants of the debounced multilevel press detector.
// ----------------------------------------------------------------------------
package dmpd_pkg;

  localparam int unsigned NUM_THRESH = 4;
  localparam int unsigned DBNC_W     = 16;
  localparam int unsigned THR_W      = 24;
  localparam int unsigned LEVEL_W    = 3;
  localparam int unsigned DUR_W      = 24;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESSED_LEVEL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_LEVELS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_1   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_2   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_3   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_4   = 3'd6;

  localparam logic [DBNC_W-1:0]  DEBOUNCE_RST  = 16'd50;
  localparam logic               PRESSED_RST   = 1'b0;
  localparam logic [LEVEL_W-1:0] NUM_LEVEL_RST = 3'd4;
  localparam logic [THR_W-1:0]   THR_1_RST     = 24'd50;
  localparam logic [THR_W-1:0]   THR_2_RST     = 24'd1000;
  localparam logic [THR_W-1:0]   THR_3_RST     = 24'd3000;
  localparam logic [THR_W-1:0]   THR_4_RST     = 24'd6000;

  localparam logic [DBNC_W-1:0] STABLE_MAX = '1;
  localparam logic [DUR_W-1:0]  DUR_MAX    = '1;

  typedef struct packed {
    logic [DBNC_W-1:0]                 debounce_ms;
    logic                              pressed_level;
    logic [LEVEL_W-1:0]                num_levels;
    logic [NUM_THRESH-1:0][THR_W-1:0]  thr;
  } cfg_t;

  // everything but the press timer, whose width is a parameter
  typedef struct packed {
    logic              prev_sample;
    logic              deb_level;
    logic [DBNC_W-1:0] stable_ticks;
    logic              press_active;
    logic [LEVEL_W-1:0] latched_level;
    logic              max_notified;
  } st_t;

  typedef struct packed {
    logic               max_reached;
    logic [LEVEL_W-1:0] press_level;
    logic [DUR_W-1:0]   press_duration;
    logic               released;
    logic               is_pressed;
  } res_t;

endpackage

### src/dmpd_step.sv
// ----------------------------------------------------------------------------
// dmpd_step
// One tick of debounce, press timing and level latching, combinational.
// ----------------------------------------------------------------------------
module dmpd_step import dmpd_pkg::*; #(
  parameter int unsigned MAX_LEVELS = 4,
  parameter int unsigned TIMER_BITS = 24
) (
  input  cfg_t                  cfg_i,
  input  logic                  sample_i,
  input  st_t                   st_i,
  input  logic [TIMER_BITS-1:0] ticks_i,
  output st_t                   st_o,
  output logic [TIMER_BITS-1:0] ticks_o,
  output res_t                  res_o
);

  localparam int unsigned CW = (TIMER_BITS > THR_W) ? TIMER_BITS : THR_W;
  localparam logic [LEVEL_W-1:0] LIM_CAP =
    LEVEL_W'((MAX_LEVELS < NUM_THRESH) ? MAX_LEVELS : NUM_THRESH);
  localparam logic [TIMER_BITS-1:0] TICKS_MAX = '1;

  logic [LEVEL_W-1:0]    lim;
  logic [LEVEL_W-1:0]    cand;
  logic [LEVEL_W-1:0]    lvl;
  logic [TIMER_BITS-1:0] ticks;
  logic [CW-1:0]         ticks_ext;
  logic [DBNC_W-1:0]     stable;
  logic                  deb;
  logic                  active;
  logic                  ended;
  logic                  maxn;
  logic                  pulse;
  logic [DUR_W-1:0]      dur;

  assign lim = (cfg_i.num_levels > LIM_CAP) ? LIM_CAP : cfg_i.num_levels;

  always_comb begin
    ticks  = ticks_i;
    stable = st_i.stable_ticks;
    deb    = st_i.deb_level;
    active = st_i.press_active;
    ended  = 1'b0;
    dur    = '0;
    lvl    = st_i.latched_level;
    maxn   = st_i.max_notified;
    pulse  = 1'b0;
    cand   = '0;

    if (active && ticks != TICKS_MAX) begin
      ticks = ticks + 1'b1;
    end
    ticks_ext = CW'(ticks);

    if (sample_i != st_i.prev_sample) begin
      stable = '0;
    end else if (stable != STABLE_MAX) begin
      stable = stable + 1'b1;
    end

    if (stable > cfg_i.debounce_ms && sample_i != deb) begin
      deb = sample_i;
      if (sample_i == cfg_i.pressed_level) begin
        active = 1'b1;
        ticks  = '0;
      end else if (active) begin
        dur    = (ticks_ext > CW'(DUR_MAX)) ? DUR_MAX : ticks_ext[DUR_W-1:0];
        active = 1'b0;
        ticks  = '0;
        ended  = 1'b1;
      end
    end

    // highest-numbered threshold in use that the press time has passed
    for (int i = 0; i < NUM_THRESH; i++) begin
      if (LEVEL_W'(i + 1) <= lim && CW'(ticks) >= CW'(cfg_i.thr[i])) begin
        cand = LEVEL_W'(i + 1);
      end
    end

    if (!ended && deb == cfg_i.pressed_level && active) begin
      if (cand > lvl) begin
        lvl = cand;
      end
      if (lvl == lim && !maxn) begin
        maxn  = 1'b1;
        pulse = 1'b1;
      end
    end

    res_o.is_pressed     = (deb == cfg_i.pressed_level);
    res_o.released       = ended;
    res_o.press_duration = dur;
    res_o.press_level    = lvl;
    res_o.max_reached    = pulse;

    st_o.prev_sample   = sample_i;
    st_o.deb_level     = deb;
    st_o.stable_ticks  = stable;
    st_o.press_active  = active;
    st_o.latched_level = ended ? '0 : lvl;
    st_o.max_notified  = ended ? 1'b0 : maxn;
    ticks_o            = ticks;
  end

endmodule

### src/debounced_multilevel_press_detector.sv
// ----------------------------------------------------------------------------
// debounced_multilevel_press_detector
// Debounces one button sample per tick, times presses against up to four
// thresholds and reports level, max pulse and duration on release.
// ----------------------------------------------------------------------------
//  channel   dir  handshake            payload
//  s_axis    in   tvalid/tready        tdata[0] pin_sample
//  m_axis    out  tvalid/tready        tdata[29:0] result fields
//  cfg       in   cfg_we_i             cfg_idx_i, cfg_data_i
//
//  one beat in, one beat out; a new sample is taken every cycle while results are taken.
//  a sample beat lands in the input register; from there, once the result
//  register is free, the step logic loads it and updates the tracking state.
//  while a result waits, the input register takes one more beat, then the
//  sample side stalls until the result is taken.
//  reset restores the register defaults and returns tracking to released.
// ----------------------------------------------------------------------------
module debounced_multilevel_press_detector import dmpd_pkg::*; #(
  parameter int unsigned MAX_LEVELS = 4,
  parameter int unsigned TIMER_BITS = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [0] pin_sample
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [0] is_pressed, [1] released, [25:2] press_duration,
  // [28:26] press_level, [29] max_reached
  output logic [31:0]           m_axis_tdata,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t                  cfg_q;
  st_t                   st_q, st_d;
  logic [TIMER_BITS-1:0] ticks_q, ticks_d;
  logic                  in_valid_q;
  logic                  in_sample_q;
  logic                  out_valid_q;
  res_t                  res_q, res_d;
  logic                  adv;

  assign adv           = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, res_q};

  dmpd_step #(
    .MAX_LEVELS (MAX_LEVELS),
    .TIMER_BITS (TIMER_BITS)
  ) u_step (
    .cfg_i    (cfg_q),
    .sample_i (in_sample_q),
    .st_i     (st_q),
    .ticks_i  (ticks_q),
    .st_o     (st_d),
    .ticks_o  (ticks_d),
    .res_o    (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms   <= DEBOUNCE_RST;
      cfg_q.pressed_level <= PRESSED_RST;
      cfg_q.num_levels    <= NUM_LEVEL_RST;
      cfg_q.thr[0]        <= THR_1_RST;
      cfg_q.thr[1]        <= THR_2_RST;
      cfg_q.thr[2]        <= THR_3_RST;
      cfg_q.thr[3]        <= THR_4_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DEBOUNCE_MS:   cfg_q.debounce_ms   <= cfg_data_i[DBNC_W-1:0];
        REG_PRESSED_LEVEL: cfg_q.pressed_level <= cfg_data_i[0];
        REG_NUM_LEVELS:    cfg_q.num_levels    <= cfg_data_i[LEVEL_W-1:0];
        REG_THRESHOLD_1:   cfg_q.thr[0]        <= cfg_data_i[THR_W-1:0];
        REG_THRESHOLD_2:   cfg_q.thr[1]        <= cfg_data_i[THR_W-1:0];
        REG_THRESHOLD_3:   cfg_q.thr[2]        <= cfg_data_i[THR_W-1:0];
        REG_THRESHOLD_4:   cfg_q.thr[3]        <= cfg_data_i[THR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      in_sample_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q  <= s_axis_tvalid;
      in_sample_q <= s_axis_tdata[0];
    end
  end

  // tracking state moves only when a beat passes into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.prev_sample   <= ~PRESSED_RST;
      st_q.deb_level     <= ~PRESSED_RST;
      st_q.stable_ticks  <= '0;
      st_q.press_active  <= 1'b0;
      st_q.latched_level <= '0;
      st_q.max_notified  <= 1'b0;
      ticks_q            <= '0;
    end else if (adv) begin
      st_q    <= st_d;
      ticks_q <= ticks_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

endmodule

### verif/press_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// press_checker
// Watches the sample, result and register channels of the press detector,
// tracks its debounce and press timing from the accepted samples and checks
// every result beat, field by field, against the oldest pending tick report.
// ----------------------------------------------------------------------------
module press_checker import dmpd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [0] pin_sample
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [0] is_pressed, [1] released, [25:2] press_duration,
  // [28:26] press_level, [29] max_reached
  input  logic [31:0]           m_axis_tdata,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  cfg_t               setup;
  logic               prev_pin;
  logic               deb_pin;
  logic [DBNC_W-1:0]  stable_cnt;
  logic               timing;
  logic [DUR_W-1:0]   press_cnt;
  logic [LEVEL_W-1:0] level_q;
  logic               max_sent;
  res_t               tick_reports_q [$];

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (fail_count_o < 100)
      $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    fail_count_o++;
  endtask

  // one tick of the detector: debounce, press timing, level latch
  task automatic step_press(input logic pin, output res_t rep);
    logic        ended;
    int unsigned in_use;
    int unsigned reached;
    ended = 1'b0;
    rep   = '0;
    if (timing && press_cnt != DUR_MAX) press_cnt++;
    if (pin != prev_pin) stable_cnt = '0;
    else if (stable_cnt != STABLE_MAX) stable_cnt++;
    if (stable_cnt > setup.debounce_ms && pin != deb_pin) begin
      deb_pin = pin;
      if (pin == setup.pressed_level) begin
        timing    = 1'b1;
        press_cnt = '0;
      end else if (timing) begin
        rep.press_duration = press_cnt;
        rep.released       = 1'b1;
        timing             = 1'b0;
        press_cnt          = '0;
        ended              = 1'b1;
      end
    end
    if (!ended && deb_pin == setup.pressed_level && timing) begin
      in_use  = (setup.num_levels > NUM_THRESH) ? NUM_THRESH : setup.num_levels;
      reached = 0;
      // highest passed index wins, thresholds need not be ordered
      for (int i = 1; i <= in_use; i++)
        if (press_cnt >= setup.thr[i-1]) reached = i;
      if (reached > level_q) level_q = reached;
      if (level_q == in_use && !max_sent) begin
        max_sent        = 1'b1;
        rep.max_reached = 1'b1;
      end
    end
    rep.press_level = level_q;
    if (ended) begin
      level_q  = '0;
      max_sent = 1'b0;
    end
    prev_pin       = pin;
    rep.is_pressed = (deb_pin == setup.pressed_level);
  endtask

  always @(posedge clk_i) begin : watch
    res_t got;
    res_t want;
    if (!rst_ni) begin
      setup.debounce_ms   = DEBOUNCE_RST;
      setup.pressed_level = PRESSED_RST;
      setup.num_levels    = NUM_LEVEL_RST;
      setup.thr[0]        = THR_1_RST;
      setup.thr[1]        = THR_2_RST;
      setup.thr[2]        = THR_3_RST;
      setup.thr[3]        = THR_4_RST;
      prev_pin            = ~PRESSED_RST;
      deb_pin             = ~PRESSED_RST;
      stable_cnt          = '0;
      timing              = 1'b0;
      press_cnt           = '0;
      level_q             = '0;
      max_sent            = 1'b0;
      tick_reports_q.delete();
    end else begin
      // compare before pushing so a beat never meets its own tick
      if (m_axis_tvalid && m_axis_tready) begin
        got = res_t'(m_axis_tdata[29:0]);
        if (tick_reports_q.size() == 0) begin
          report_mismatch("result beat with nothing pending", got, 0);
        end else begin
          want = tick_reports_q.pop_front();
          if (got.is_pressed != want.is_pressed)
            report_mismatch("is_pressed", got.is_pressed, want.is_pressed);
          if (got.released != want.released)
            report_mismatch("released", got.released, want.released);
          if (got.press_duration != want.press_duration)
            report_mismatch("press_duration", got.press_duration, want.press_duration);
          if (got.press_level != want.press_level)
            report_mismatch("press_level", got.press_level, want.press_level);
          if (got.max_reached != want.max_reached)
            report_mismatch("max_reached", got.max_reached, want.max_reached);
          if (m_axis_tdata[31:30] != 2'b00)
            report_mismatch("tdata pad bits", m_axis_tdata[31:30], 0);
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_DEBOUNCE_MS:   setup.debounce_ms   = cfg_data_i[DBNC_W-1:0];
          REG_PRESSED_LEVEL: setup.pressed_level = cfg_data_i[0];
          REG_NUM_LEVELS:    setup.num_levels    = cfg_data_i[LEVEL_W-1:0];
          REG_THRESHOLD_1:   setup.thr[0]        = cfg_data_i[THR_W-1:0];
          REG_THRESHOLD_2:   setup.thr[1]        = cfg_data_i[THR_W-1:0];
          REG_THRESHOLD_3:   setup.thr[2]        = cfg_data_i[THR_W-1:0];
          REG_THRESHOLD_4:   setup.thr[3]        = cfg_data_i[THR_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        step_press(s_axis_tdata[0], want);
        tick_reports_q.push_back(want);
      end
    end
    pending_o <= tick_reports_q.size();
  end

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives raw button samples into the press detector: a few directed press
// sequences, then phases of bouncy presses of random length under random
// register settings, with random gaps and back-pressure on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import dmpd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic [7:0]            s_axis_tdata  = '0;
  logic                  m_axis_tready = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  wire                   s_axis_tready;
  wire                   m_axis_tvalid;
  wire  [31:0]           m_axis_tdata;

  int                fail_count;
  int                pending;
  int                cycles     = 0;
  int                items_sent = 0;
  bit                tx_calm    = 1'b0;
  bit                rx_calm    = 1'b0;
  int                rx_stall_pct = 20;
  int                rx_hold    = 0;
  int                press_span = 45;
  logic [DBNC_W-1:0] cur_debounce = DEBOUNCE_RST;
  logic              cur_pressed  = PRESSED_RST;

  debounced_multilevel_press_detector u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  press_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (cycles == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
    cycles <= cycles + 1;
  end

  // result side back-pressure: mostly short stalls, now and then a long one
  always @(posedge clk_i) begin
    if (rx_hold > 0) begin
      m_axis_tready <= 1'b0;
      rx_hold       <= rx_hold - 1;
    end else if (rx_calm || $urandom_range(0, 99) >= rx_stall_pct) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= 1'b0;
      rx_hold       <= ($urandom_range(0, 19) == 0) ? $urandom_range(8, 30)
                                                     : $urandom_range(0, 2);
    end
  end

  task automatic send_pin(input logic pin);
    int roll;
    int gap;
    gap = 0;
    if (!tx_calm) begin
      roll = $urandom_range(0, 99);
      gap  = (roll < 70) ? 0 : (roll < 96) ? $urandom_range(1, 3) : $urandom_range(8, 30);
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, pin};
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic hold_level(input logic pin, input int len);
    for (int k = 0; k < len; k++) send_pin(pin);
  endtask

  // sends bits msb first
  task automatic send_pattern(input logic [15:0] bits, input int count);
    for (int k = count - 1; k >= 0; k--) send_pin(bits[k]);
  endtask

  task automatic send_noise();
    int len;
    len = $urandom_range(1, 5);
    for (int k = 0; k < len; k++) send_pin($urandom_range(0, 1));
  endtask

  // wait for every pending result, then let the pipeline go quiet
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data[CFG_DATA_W-1:0];
    @(posedge clk_i);
    if (idx == REG_DEBOUNCE_MS) cur_debounce = data[DBNC_W-1:0];
    if (idx == REG_PRESSED_LEVEL) cur_pressed = data[0];
  endtask

  task automatic end_writes();
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_random_setup(input bit every_reg);
    logic [THR_W-1:0] thr [NUM_THRESH];
    int unsigned      roll;
    roll = $urandom_range(0, 9);
    if (every_reg || $urandom_range(0, 1))
      write_reg(REG_DEBOUNCE_MS, (roll < 6) ? $urandom_range(0, 3) :
                                 (roll < 9) ? $urandom_range(4, 12) : $urandom_range(20, 30));
    // flipping the polarity alone leaves any press in flight as it is
    if (every_reg || $urandom_range(0, 1))
      write_reg(REG_PRESSED_LEVEL, $urandom_range(0, 1));
    if (every_reg || $urandom_range(0, 1))
      write_reg(REG_NUM_LEVELS, $urandom_range(0, 7));
    if (every_reg || $urandom_range(0, 1)) begin
      roll   = $urandom_range(0, 7);
      thr[0] = $urandom_range(0, 8);
      for (int i = 1; i < NUM_THRESH; i++)
        thr[i] = (roll < 5) ? thr[i-1] + $urandom_range(0, 12) : $urandom_range(0, 40);
      if (roll == 7) thr[NUM_THRESH-1] = '1;
      write_reg(REG_THRESHOLD_1, thr[0]);
      write_reg(REG_THRESHOLD_2, thr[1]);
      write_reg(REG_THRESHOLD_3, thr[2]);
      write_reg(REG_THRESHOLD_4, thr[3]);
    end
    end_writes();
  endtask

  // bounce, hold pressed, bounce, hold released; some holds too short to count
  task automatic random_press();
    int len;
    if ($urandom_range(0, 3) == 0) send_noise();
    if ($urandom_range(0, 5) == 0) len = $urandom_range(1, cur_debounce + 1);
    else len = cur_debounce + 2 + $urandom_range(0, press_span);
    hold_level(cur_pressed, len);
    if ($urandom_range(0, 2) == 0) send_noise();
    if ($urandom_range(0, 5) == 0) len = $urandom_range(1, cur_debounce + 1);
    else len = cur_debounce + 2 + $urandom_range(0, 10);
    hold_level(~cur_pressed, len);
  endtask

  task automatic run_presses(input int stop_at);
    while (items_sent < stop_at) random_press();
    settle();
  endtask

  initial begin : stimulus
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    settle();

    // high active, no debounce, thresholds one apart: every level in turn
    write_reg(REG_DEBOUNCE_MS, 0);
    write_reg(REG_PRESSED_LEVEL, 1);
    write_reg(REG_NUM_LEVELS, 4);
    write_reg(REG_THRESHOLD_1, 1);
    write_reg(REG_THRESHOLD_2, 2);
    write_reg(REG_THRESHOLD_3, 3);
    write_reg(REG_THRESHOLD_4, 4);
    end_writes();
    send_pattern(16'b110011111110100, 15);
    settle();
    // no levels in use: max pulse on the accepting tick
    write_reg(REG_NUM_LEVELS, 0);
    end_writes();
    send_pattern(16'b1100, 4);
    settle();
    // longest debounce: nothing is ever accepted
    write_reg(REG_DEBOUNCE_MS, STABLE_MAX);
    end_writes();
    send_pattern(16'b0011, 4);
    settle();

    // reset values again, with holds long enough to pass the first level
    write_reg(REG_DEBOUNCE_MS, DEBOUNCE_RST);
    write_reg(REG_PRESSED_LEVEL, PRESSED_RST);
    write_reg(REG_NUM_LEVELS, NUM_LEVEL_RST);
    write_reg(REG_THRESHOLD_1, THR_1_RST);
    write_reg(REG_THRESHOLD_2, THR_2_RST);
    write_reg(REG_THRESHOLD_3, THR_3_RST);
    write_reg(REG_THRESHOLD_4, THR_4_RST);
    end_writes();
    press_span = 80;
    run_presses(items_sent + 250);

    press_span = 45;
    for (int phase = 0; phase < 10; phase++) begin
      tx_calm       = ($urandom_range(0, 3) == 0);
      rx_calm      <= ($urandom_range(0, 3) == 0);
      rx_stall_pct <= $urandom_range(5, 40);
      write_random_setup(phase == 0);
      run_presses(items_sent + 95);
    end

    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

### debounced_multilevel_press_detector.f
src/dmpd_pkg.sv
src/dmpd_step.sv
src/debounced_multilevel_press_detector.sv
verif/press_checker.sv
verif/testbench.sv
